>>> hdl/qsd_pkg.sv
package qsd_pkg;

    // Widths fixed by the field definitions.
    localparam int CNT_W         = 14;
    localparam int BYTE_W        = 8;
    localparam int MAX_INPUT_DEF = 8192;
    localparam int LIMIT_CEIL    = 16383;

    // Result queue depth; two entries must stay free for a worst-case item.
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);

    // Characters with a special meaning in a query string.
    localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_AMP     = 8'h26;
    localparam logic [BYTE_W-1:0] CH_EQUAL   = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [BYTE_W-1:0] CH_NUL     = 8'h00;

    typedef enum logic [2:0] {
        KIND_NAME     = 3'd0,
        KIND_VALUE    = 3'd1,
        KIND_RESTART  = 3'd2,
        KIND_PAIR_END = 3'd3,
        KIND_DONE     = 3'd4,
        KIND_ERROR    = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_FIRST,
        ESC_SECOND
    } esc_t;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              end_of_input;
    } item_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data_byte;
        logic              drop_pair;
        logic              last;
    } result_t;

    // Up to two results produced by one item, handed to the result queue.
    typedef struct packed {
        logic [1:0] cnt;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic result_t make_result(input kind_t k, input logic [BYTE_W-1:0] d,
                                            input logic drop);
        result_t r;
        r.kind      = k;
        r.data_byte = d;
        r.drop_pair = drop;
        r.last      = 1'b0;
        return r;
    endfunction

    // C-locale whitespace: space, tab, newline, vertical tab, form feed, return.
    function automatic logic is_space(input logic [BYTE_W-1:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // Returns {valid, value} for one hex digit.
    function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] t;
        t = 8'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            t = c - 8'h30;
            return {1'b1, t[3:0]};
        end
        if (c >= 8'h61 && c <= 8'h66) begin
            t = c - 8'h57;
            return {1'b1, t[3:0]};
        end
        if (c >= 8'h41 && c <= 8'h46) begin
            t = c - 8'h37;
            return {1'b1, t[3:0]};
        end
        return 5'd0;
    endfunction

    // Reads a two-character string as a base-16 number: leading whitespace,
    // an optional sign, then hex digits. A zero first byte ends the string.
    function automatic logic [BYTE_W-1:0] decode_escape(input logic [BYTE_W-1:0] a,
                                                        input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] s [2];
        logic [BYTE_W-1:0] v;
        logic [4:0]        h;
        logic              neg;
        logic              in_ws;
        logic              stop;
        s[0]  = a;
        s[1]  = (a == CH_NUL) ? CH_NUL : b;
        v     = '0;
        neg   = 1'b0;
        in_ws = 1'b1;
        stop  = 1'b0;
        for (int k = 0; k < 2; k++) begin
            h = hex_digit(s[k]);
            if (!stop) begin
                if (in_ws && is_space(s[k])) begin
                    // Still skipping leading whitespace.
                    in_ws = 1'b1;
                end else if (in_ws && (s[k] == CH_PLUS || s[k] == CH_MINUS)) begin
                    neg   = (s[k] == CH_MINUS);
                    in_ws = 1'b0;
                end else if (h[4]) begin
                    v     = {v[3:0], h[3:0]};
                    in_ws = 1'b0;
                end else begin
                    stop = 1'b1;
                end
            end
        end
        return neg ? (~v + 8'd1) : v;
    endfunction

endpackage

>>> hdl/qsd_core.sv
module qsd_core #(
    parameter int MAX_INPUT = qsd_pkg::MAX_INPUT_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      take,
    input  qsd_pkg::item_t            item,
    input  logic                      limit_wr_en,
    input  logic [qsd_pkg::CNT_W-1:0] limit_wr_data,
    output qsd_pkg::push_t            push
);
    import qsd_pkg::*;

    localparam int LIM_CAP = (MAX_INPUT > LIMIT_CEIL) ? LIMIT_CEIL : MAX_INPUT;
    localparam logic [CNT_W-1:0] LIM_CAP_V = LIM_CAP[CNT_W-1:0];

    logic [CNT_W-1:0]  limit_reg;
    esc_t              esc_reg, esc_mid, esc_next;
    logic [BYTE_W-1:0] fd_reg, fd_mid, fd_next;
    logic              inval_reg, inval_mid, inval_next;
    logic              nn_reg, nn_mid, nn_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_mid, cnt_next;
    logic              lr_reg, lr_mid, lr_next;

    logic [CNT_W-1:0]  lim;
    logic [CNT_W-1:0]  cnt_inc;
    logic [BYTE_W-1:0] c_in;
    logic [BYTE_W-1:0] c_tr;
    logic              esc_fits;
    logic [1:0]        main_n;
    result_t           main_a, main_b;
    logic              flush;

    // Byte budget register; write it only while the block is idle (not enforced here).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIM_CAP_V;
        end
        else if (limit_wr_en)
        begin
            limit_reg <= limit_wr_data;
        end
    end

    // Effective limit and the small arithmetic on the byte count.
    assign lim      = (limit_reg < LIM_CAP_V) ? limit_reg : LIM_CAP_V;
    assign cnt_inc  = cnt_reg + 1'b1;
    assign c_in     = item.in_byte;
    assign c_tr     = (c_in == CH_PLUS) ? CH_SPACE : c_in;
    assign esc_fits = ({1'b0, cnt_inc} + 15'd2) <= {1'b0, lim};

    // Main decode of one word: state update and up to two results.
    always_comb
    begin
        esc_mid   = esc_reg;
        fd_mid    = fd_reg;
        inval_mid = inval_reg;
        nn_mid    = nn_reg;
        cnt_mid   = cnt_reg;
        lr_mid    = lr_reg;
        main_n    = 2'd0;
        main_a    = make_result(KIND_DONE, '0, 1'b0);
        main_b    = make_result(KIND_DONE, '0, 1'b0);
        if (item.end_of_input)
        begin
            if (esc_reg != ESC_NONE)
            begin
                main_n = 2'd1;
                main_a = make_result(KIND_ERROR, '0, 1'b0);
            end
            else if (!lr_reg)
            begin
                main_n = 2'd2;
                main_a = make_result(KIND_PAIR_END, '0, !nn_reg);
            end
            else
            begin
                main_n = 2'd1;
            end
            esc_mid   = ESC_NONE;
            fd_mid    = '0;
            inval_mid = 1'b0;
            nn_mid    = 1'b0;
            cnt_mid   = '0;
            lr_mid    = 1'b0;
        end
        else if (!lr_reg)
        begin
            case (esc_reg)
                ESC_FIRST:
                begin
                    fd_mid  = c_in;
                    esc_mid = ESC_SECOND;
                    cnt_mid = cnt_inc;
                end
                ESC_SECOND:
                begin
                    esc_mid = ESC_NONE;
                    cnt_mid = cnt_inc;
                    main_n  = 2'd1;
                    main_a  = make_result(inval_reg ? KIND_VALUE : KIND_NAME,
                                          decode_escape(fd_reg, c_in), 1'b0);
                    if (!inval_reg)
                    begin
                        nn_mid = 1'b1;
                    end
                end
                default:
                begin
                    if (cnt_reg >= lim)
                    begin
                        // Budget already spent: close the pair, drop this byte.
                        main_n    = 2'd1;
                        main_a    = make_result(KIND_PAIR_END, '0, !nn_reg);
                        inval_mid = 1'b0;
                        nn_mid    = 1'b0;
                        lr_mid    = 1'b1;
                    end
                    else
                    begin
                        cnt_mid = cnt_inc;
                        main_n  = 2'd1;
                        if (c_tr == CH_AMP)
                        begin
                            main_a    = make_result(KIND_PAIR_END, '0, !nn_reg);
                            inval_mid = 1'b0;
                            nn_mid    = 1'b0;
                        end
                        else if (c_tr == CH_EQUAL)
                        begin
                            main_a    = make_result(KIND_RESTART, '0, 1'b0);
                            inval_mid = 1'b1;
                        end
                        else if (c_tr == CH_PERCENT && esc_fits)
                        begin
                            main_n  = 2'd0;
                            esc_mid = ESC_FIRST;
                        end
                        else
                        begin
                            main_a = make_result(inval_reg ? KIND_VALUE : KIND_NAME,
                                                 c_tr, 1'b0);
                            if (!inval_reg)
                            begin
                                nn_mid = 1'b1;
                            end
                        end
                    end
                end
            endcase
        end
    end

    // Flush when this word used up the budget, then mark the last result.
    assign flush = !item.end_of_input && !lr_mid && (esc_mid == ESC_NONE) && (cnt_mid >= lim);

    always_comb
    begin
        esc_next    = esc_mid;
        fd_next     = fd_mid;
        inval_next  = inval_mid;
        nn_next     = nn_mid;
        cnt_next    = cnt_mid;
        lr_next     = lr_mid;
        push.cnt    = main_n;
        push.first  = main_a;
        push.second = main_b;
        if (flush)
        begin
            inval_next = 1'b0;
            nn_next    = 1'b0;
            lr_next    = 1'b1;
            if (main_n == 2'd0)
            begin
                push.cnt   = 2'd1;
                push.first = make_result(KIND_PAIR_END, '0, !nn_mid);
            end
            else
            begin
                push.cnt    = 2'd2;
                push.second = make_result(KIND_PAIR_END, '0, !nn_mid);
            end
        end
        if (push.cnt == 2'd1)
        begin
            push.first.last = 1'b1;
        end
        if (push.cnt == 2'd2)
        begin
            push.second.last = 1'b1;
        end
        if (!take)
        begin
            push.cnt = 2'd0;
        end
    end

    // Per-string decoder state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg   <= ESC_NONE;
            fd_reg    <= '0;
            inval_reg <= 1'b0;
            nn_reg    <= 1'b0;
            cnt_reg   <= '0;
            lr_reg    <= 1'b0;
        end
        else if (take)
        begin
            esc_reg   <= esc_next;
            fd_reg    <= fd_next;
            inval_reg <= inval_next;
            nn_reg    <= nn_next;
            cnt_reg   <= cnt_next;
            lr_reg    <= lr_next;
        end
    end

    // End of input always leaves the decoder ready for a fresh string.
    a_eoi_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take && item.end_of_input |=> esc_reg == ESC_NONE && cnt_reg == '0 && !lr_reg)
        else $error("state not cleared after end of input");

    // The limit is never marked while an escape is still open.
    a_limit_no_escape: assert property (@(posedge clk) disable iff (!rst_n)
        lr_reg |-> esc_reg == ESC_NONE)
        else $error("limit reached with escape pending");

    // A pair end that is the only result of its word leaves the decoder collecting a name.
    a_pair_end_name: assert property (@(posedge clk) disable iff (!rst_n)
        take && push.cnt != 2'd0 && push.first.kind == KIND_PAIR_END && push.cnt == 2'd1
        |=> !inval_reg && !nn_reg)
        else $error("pair end did not return to name collection");

endmodule

>>> hdl/qsd_result_queue.sv
module qsd_result_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  qsd_pkg::push_t   push,
    output logic             room,
    output qsd_pkg::result_t result,
    output logic             result_valid,
    input  logic             result_stall
);
    import qsd_pkg::*;

    result_t             entry_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RQ_PTR_W:0]   count_reg, count_next;
    logic                pop;
    logic [RQ_PTR_W-1:0] wr_ptr_plus1;

    // Head of the queue drives the output word directly.
    assign result       = entry_reg[rd_ptr_reg];
    assign result_valid = (count_reg != '0);
    assign pop          = result_valid && !result_stall;
    assign room         = count_reg <= (RQ_PTR_W + 1)'(RQ_DEPTH - 2);
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    // Pointer and fill level update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RQ_PTR_W'(push.cnt);
        rd_ptr_next = pop ? (rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg + (RQ_PTR_W + 1)'(push.cnt) - (RQ_PTR_W + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage; one or two words written per cycle.
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.cnt == 2'd2)
        begin
            entry_reg[wr_ptr_plus1] <= push.second;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (RQ_PTR_W + 1)'(RQ_DEPTH))
        else $error("result queue overflow");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt != 2'd0 |-> room)
        else $error("push into result queue without room");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        pop && push.cnt == 2'd0 |=> count_reg == $past(count_reg) - 1'b1)
        else $error("result queue level did not drop on pop");

endmodule

>>> hdl/query_string_decoder.sv
// Query string decoder: takes a URL-encoded query string one byte per word and
// emits tagged name bytes, value bytes, value restarts, pair ends and a final
// done or error marker.
// Input channel: item_valid / item_stall / item. A word is taken at a rising
// edge with item_valid high and item_stall low; end_of_input closes a string.
// Output channel: result_valid / result_stall / result, one result per word,
// with last set on the final result caused by one input word.
// Configuration: limit_wr_en / limit_wr_data write the byte budget; write it
// only while no string is in flight.
// Path: an accepted word is registered in the input stage, decoded from there into
// the result queue, and the queue head drives result directly.
// Throughput: one input word per cycle while item_stall is low. A word with two
// results (pair end plus done, or a byte that uses up the budget) puts both into
// the queue at once; the four-entry result queue sets how far the input runs ahead.
// Reset (rst_n low) empties the queue, clears the per-string state and sets
// the budget to its maximum. When the receiver stalls, the queue fills and
// item_stall rises once fewer than two free entries remain while a word waits in the input stage.
module query_string_decoder #(
    parameter int MAX_INPUT = qsd_pkg::MAX_INPUT_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_stall,
    input  qsd_pkg::item_t            item,
    output logic                      result_valid,
    input  logic                      result_stall,
    output qsd_pkg::result_t          result,
    input  logic                      limit_wr_en,
    input  logic [qsd_pkg::CNT_W-1:0] limit_wr_data
);
    import qsd_pkg::*;

    logic  stage_valid_reg, stage_valid_next;
    item_t stage_item_reg;
    logic  room;
    logic  take;
    logic  accept;
    push_t push;

    // Input register stage; drains into the decoder whenever the queue has room.
    assign take       = stage_valid_reg && room;
    assign item_stall = stage_valid_reg && !room;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (take)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_item_reg <= item;
        end
    end

    qsd_core #(
        .MAX_INPUT (MAX_INPUT)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .item          (stage_item_reg),
        .limit_wr_en   (limit_wr_en),
        .limit_wr_data (limit_wr_data),
        .push          (push)
    );

    qsd_result_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room         (room),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !take |=> stage_valid_reg && $stable(stage_item_reg))
        else $error("input stage lost a stalled word");

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import qsd_pkg::*;

    localparam int MAX_INPUT   = MAX_INPUT_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PHASES = 10;
    localparam int WORDS_PER_PHASE = 12;
    localparam string HEX_CHARS = "0123456789abcdefABCDEF";

    logic                clk;
    logic                rst_n;
    logic                item_valid;
    logic                item_stall;
    item_t               item_word;
    logic                result_valid;
    logic                result_stall;
    result_t             result_word;
    logic                limit_wr_en;
    logic [CNT_W-1:0]    limit_wr_data;

    // Decoder state as the predictor sees it.
    logic [CNT_W-1:0]    dec_limit;
    logic                dec_in_value;
    esc_t                dec_escape;
    logic [BYTE_W-1:0]   dec_first;
    logic                dec_name_seen;
    int                  dec_count;
    logic                dec_limit_hit;

    // Results still owed by the block, oldest first, and the ones of the current word.
    result_t             expected_results[$];
    result_t             word_results[$];

    int                  error_count;
    int                  cycle_count;
    int                  words_sent;
    logic                sender_gaps;

    // Long hold requested by a test and carried out by the result process.
    logic                hold_toggle;
    logic                hold_seen;
    int                  hold_len;
    int                  hold_left;
    int                  stall_left;
    int                  flow_left;

    query_string_decoder #(
        .MAX_INPUT(MAX_INPUT)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_word),
        .limit_wr_en  (limit_wr_en),
        .limit_wr_data(limit_wr_data)
    );

    // Free-running clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic result_t result_of(input kind_t k, input logic [BYTE_W-1:0] d,
                                          input logic drop);
        result_t r;
        r.kind      = k;
        r.data_byte = d;
        r.drop_pair = drop;
        r.last      = 1'b0;
        return r;
    endfunction

    function automatic int hex_value(input logic [BYTE_W-1:0] c);
        if (c >= "0" && c <= "9")
            return int'(c) - int'("0");
        if (c >= "a" && c <= "f")
            return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic logic is_blank(input logic [BYTE_W-1:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // Two escape characters read as a base-16 number: blanks, a sign, hex digits.
    function automatic logic [BYTE_W-1:0] unescape(input logic [BYTE_W-1:0] a,
                                                   input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] s[2];
        int                i;
        int                v;
        logic              neg;
        s[0] = a;
        s[1] = (a == CH_NUL) ? CH_NUL : b;
        i    = 0;
        v    = 0;
        neg  = 1'b0;
        while (i < 2 && is_blank(s[i]))
            i++;
        if (i < 2 && (s[i] == CH_PLUS || s[i] == CH_MINUS))
        begin
            neg = (s[i] == CH_MINUS);
            i++;
        end
        while (i < 2 && hex_value(s[i]) >= 0)
        begin
            v = v * 16 + hex_value(s[i]);
            i++;
        end
        if (neg)
            v = -v;
        return v[BYTE_W-1:0];
    endfunction

    // Ending a pair flags it for discard when its name stayed empty.
    function automatic void close_pair();
        word_results.push_back(result_of(KIND_PAIR_END, CH_NUL, !dec_name_seen));
        dec_in_value  = 1'b0;
        dec_name_seen = 1'b0;
    endfunction

    function automatic void emit_data(input logic [BYTE_W-1:0] c);
        if (dec_in_value)
            word_results.push_back(result_of(KIND_VALUE, c, 1'b0));
        else
        begin
            word_results.push_back(result_of(KIND_NAME, c, 1'b0));
            dec_name_seen = 1'b1;
        end
    endfunction

    function automatic void clear_string();
        dec_in_value  = 1'b0;
        dec_escape    = ESC_NONE;
        dec_first     = '0;
        dec_name_seen = 1'b0;
        dec_count     = 0;
        dec_limit_hit = 1'b0;
    endfunction

    // Works out the results of one accepted word and queues them.
    function automatic void predict_word(input item_t w);
        logic [BYTE_W-1:0] c;
        int                lim;
        c   = w.in_byte;
        lim = (int'(dec_limit) < MAX_INPUT) ? int'(dec_limit) : MAX_INPUT;
        word_results.delete();

        if (w.end_of_input)
        begin
            // Ending inside an escape is an error with no pair end.
            if (dec_escape != ESC_NONE)
                word_results.push_back(result_of(KIND_ERROR, CH_NUL, 1'b0));
            else
            begin
                if (!dec_limit_hit)
                    close_pair();
                word_results.push_back(result_of(KIND_DONE, CH_NUL, 1'b0));
            end
            clear_string();
        end
        else if (dec_limit_hit)
        begin
            // Budget used up: bytes are ignored until end of input.
        end
        else if (dec_escape == ESC_FIRST)
        begin
            dec_first  = c;
            dec_escape = ESC_SECOND;
            dec_count++;
        end
        else if (dec_escape == ESC_SECOND)
        begin
            dec_escape = ESC_NONE;
            dec_count++;
            emit_data(unescape(dec_first, c));
        end
        else if (dec_count >= lim)
        begin
            close_pair();
            dec_limit_hit = 1'b1;
        end
        else
        begin
            dec_count++;
            if (c == CH_PLUS)
                c = CH_SPACE;
            if (c == CH_AMP)
                close_pair();
            else if (c == CH_EQUAL)
            begin
                dec_in_value = 1'b1;
                word_results.push_back(result_of(KIND_RESTART, CH_NUL, 1'b0));
            end
            else if (c == CH_PERCENT && dec_count + 2 <= lim)
                dec_escape = ESC_FIRST;
            else
                emit_data(c);
        end

        // A byte that uses up the budget flushes the pair at once.
        if (!w.end_of_input && !dec_limit_hit && dec_escape == ESC_NONE && dec_count >= lim)
        begin
            close_pair();
            dec_limit_hit = 1'b1;
        end

        if (word_results.size() > 0)
            word_results[word_results.size() - 1].last = 1'b1;
        foreach (word_results[k])
            expected_results.push_back(word_results[k]);
    endfunction

    // Compares one accepted result with the oldest expectation.
    task automatic check_result(input result_t got);
        result_t want;
        if (expected_results.size() == 0)
        begin
            $display("%0t: unexpected result kind %0d data %h drop %b last %b",
                     $time, got.kind, got.data_byte, got.drop_pair, got.last);
            error_count++;
        end
        else
        begin
            want = expected_results.pop_front();
            if (got.kind !== want.kind)
            begin
                $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
                error_count++;
            end
            if (got.data_byte !== want.data_byte)
            begin
                $display("%0t: data_byte expected %h actual %h", $time,
                         want.data_byte, got.data_byte);
                error_count++;
            end
            if (got.drop_pair !== want.drop_pair)
            begin
                $display("%0t: drop_pair expected %b actual %b", $time,
                         want.drop_pair, got.drop_pair);
                error_count++;
            end
            if (got.last !== want.last)
            begin
                $display("%0t: last expected %b actual %b", $time, want.last, got.last);
                error_count++;
            end
        end
    endtask

    // Result side: checks each accepted word and drives random stalls.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            check_result(result_word);
        if (hold_toggle != hold_seen)
        begin
            hold_seen = hold_toggle;
            hold_left = hold_len;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else if (flow_left > 0)
        begin
            flow_left--;
            result_stall <= 1'b0;
        end
        else
        begin
            stall_left = idle_len();
            flow_left  = ($urandom_range(0, 99) < 15) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 10);
            result_stall <= 1'b0;
        end
    end

    // Offers one word, after a random gap when sender gaps are on, and waits until it is taken.
    task automatic send_word(input item_t w);
        int gap;
        gap = sender_gaps ? idle_len() : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item_word  <= w;
        do
            @(posedge clk);
        while (item_stall);
        predict_word(w);
        words_sent++;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        item_t w;
        w.in_byte      = b;
        w.end_of_input = 1'b0;
        send_word(w);
    endtask

    // End of input carries a random, ignored byte.
    task automatic send_end();
        item_t w;
        w.in_byte      = BYTE_W'($urandom_range(0, 255));
        w.end_of_input = 1'b1;
        send_word(w);
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send_byte(s[k]);
    endtask

    // Waits until every owed result has come, then lets the block settle.
    task automatic wait_idle();
        item_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [CNT_W-1:0] v);
        wait_idle();
        limit_wr_en   <= 1'b1;
        limit_wr_data <= v;
        @(posedge clk);
        limit_wr_en   <= 1'b0;
        dec_limit = v;
    endtask

    // One character of an escape: mostly hex digits, some blanks, signs and noise.
    function automatic logic [BYTE_W-1:0] escape_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return HEX_CHARS[$urandom_range(0, HEX_CHARS.len() - 1)];
        if (r < 65)
            return CH_SPACE;
        if (r < 70)
            return BYTE_W'($urandom_range(9, 13));
        if (r < 74)
            return CH_MINUS;
        if (r < 78)
            return CH_PLUS;
        if (r < 83)
            return CH_NUL;
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // A query string of random tokens; sometimes cut off inside an escape.
    task automatic send_random_string();
        int tokens;
        int r;
        tokens = $urandom_range(0, 12);
        for (int k = 0; k < tokens; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
                send_byte(BYTE_W'($urandom_range(8'h61, 8'h7A)));
            else if (r < 45)
                send_byte(CH_EQUAL);
            else if (r < 55)
                send_byte(CH_AMP);
            else if (r < 62)
                send_byte(CH_PLUS);
            else if (r < 80)
            begin
                send_byte(CH_PERCENT);
                if ($urandom_range(0, 11) == 0)
                    break;
                send_byte(escape_char());
                if ($urandom_range(0, 11) == 0)
                    break;
                send_byte(escape_char());
            end
            else if (r < 93)
                send_byte(BYTE_W'($urandom_range(0, 255)));
            else
                send_byte($urandom_range(0, 1) ? 8'hFF : CH_NUL);
        end
        send_end();
    endtask

    // Separators, empty names, plus signs, byte extremes and escape forms.
    task automatic test_syntax();
        send_byte(CH_AMP);
        send_byte(CH_PLUS);
        send_byte(CH_NUL);
        send_byte(8'hFF);
        send_byte(CH_EQUAL);
        send_text("%-1");
        send_text("%\tA");
        send_byte(CH_EQUAL);
        send_byte(CH_PERCENT);
        send_byte(CH_NUL);
        send_byte("F");
        send_end();
        // End of input inside an escape.
        send_text("%4");
        send_end();
    endtask

    // Literal percent near the budget, flush on the limit, and a zero budget.
    task automatic test_limits();
        write_limit(CNT_W'(3));
        send_text("ab%z");
        send_end();
        write_limit(CNT_W'(0));
        send_text("q");
        send_end();
    endtask

    // The receiver holds off while words arrive back to back, filling the block.
    task automatic test_backpressure();
        write_limit(CNT_W'(LIMIT_CEIL));
        sender_gaps = 1'b0;
        hold_len    = 150;
        hold_toggle = ~hold_toggle;
        send_text("name=value&x+y=%41%62cdefghijklmn");
        send_end();
        sender_gaps = 1'b1;
    endtask

    // Random strings over a range of budgets, the extremes among them.
    task automatic test_random_strings();
        int limit_plan[RANDOM_PHASES];
        int target;
        limit_plan = '{7, LIMIT_CEIL, 2, 12, 1, 0, 20, MAX_INPUT, 4, 9};
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_limit(CNT_W'(limit_plan[p]));
            sender_gaps = (p % 3 != 1);
            target = words_sent + WORDS_PER_PHASE;
            while (words_sent < target)
                send_random_string();
        end
        sender_gaps = 1'b1;
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        item_word     = '0;
        result_stall  = 1'b0;
        limit_wr_en   = 1'b0;
        limit_wr_data = '0;
        error_count   = 0;
        cycle_count   = 0;
        words_sent    = 0;
        sender_gaps   = 1'b1;
        hold_toggle   = 1'b0;
        hold_seen     = 1'b0;
        hold_len      = 0;
        hold_left     = 0;
        stall_left    = 0;
        flow_left     = 0;
        dec_limit     = CNT_W'((MAX_INPUT > LIMIT_CEIL) ? LIMIT_CEIL : MAX_INPUT);
        clear_string();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_syntax();
        test_limits();
        test_backpressure();
        test_random_strings();

        // Drain, then allow the pipeline to settle before the verdict.
        wait_idle();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
hdl/qsd_pkg.sv
hdl/qsd_core.sv
hdl/qsd_result_queue.sv
hdl/query_string_decoder.sv
sim/tb.sv
